### hdl/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg: shared types and constants for the differential throttle mixer
// Payload structs, configuration bundle, register indexes and range helper.
// ----------------------------------------------------------------------------
package dtm_pkg;

  // Pulse widths are microsecond ticks held in 15 unsigned bits.
  localparam int RegW      = 15;
  localparam int CfgIndexW = 2;

  // Signed working width: wide enough for every sum and difference of the
  // mix, including the lowered side after a floor correction.
  localparam int SumW = RegW + 3;

  localparam logic [RegW-1:0] GyroCentre = RegW'(1500);
  localparam logic [RegW-1:0] ResetLow   = RegW'(700);
  localparam logic [RegW-1:0] ResetHigh  = RegW'(2300);

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_THROTTLE_LOW  = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] REG_THROTTLE_HIGH = CfgIndexW'(1);
  localparam logic [CfgIndexW-1:0] REG_GYRO_LOW      = CfgIndexW'(2);
  localparam logic [CfgIndexW-1:0] REG_GYRO_HIGH     = CfgIndexW'(3);

  typedef logic [RegW-1:0]        width_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    width_t throttle_width;
    width_t gyro_width;
  } sample_t;

  typedef struct packed {
    width_t left_motor;
    width_t right_motor;
    logic   updated;
  } mix_t;

  typedef struct packed {
    width_t throttle_low;
    width_t throttle_high;
    width_t gyro_low;
    width_t gyro_high;
  } cfg_t;

  // Zero-extend an unsigned width into the signed working width.
  function automatic sum_t widen(input width_t w);
    widen = $signed({{(SumW-RegW){1'b0}}, w});
  endfunction

  // Inclusive range check on signed working values.
  function automatic logic within_limits(input sum_t v, input width_t lo, input width_t hi);
    within_limits = (v >= widen(lo)) && (v <= widen(hi));
  endfunction

endpackage

### hdl/differential_throttle_mixer.sv
// ----------------------------------------------------------------------------
// differential_throttle_mixer: two-motor throttle and gyro mixer
// Turns each throttle/gyro pulse-width pair into left and right motor widths.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                         Direction  Beat content
//   sample    sample_valid/_stall, sample     in         throttle, gyro widths
//   mix       mix_valid/_stall, mix           out        left, right, updated
//   cfg       cfg_write, cfg_index, cfg_data  in         one limit register
//
// Every sample beat yields exactly one mix beat, through the input register
// and then the output register. One beat is accepted per cycle unless sample
// is stalled; a short add, shift and compare path joins the two registers.
// Synchronous reset empties both registers and restores the limits and the
// held motor widths to their power-on values. A stall on mix only stalls
// sample once both registers hold a beat.
// ----------------------------------------------------------------------------
module differential_throttle_mixer import dtm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 mix_valid,
  input  logic                 mix_stall,
  output mix_t                 mix,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  width_t               cfg_data
);

  cfg_t    cfg;
  sample_t stage;
  logic    stage_valid;
  width_t  left_hold;
  width_t  right_hold;
  mix_t    result;
  logic    advance;
  logic    take;

  dtm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The mix works on the staged beat against the currently held widths.
  dtm_mix u_mix (
    .sample     (stage),
    .cfg        (cfg),
    .left_hold  (left_hold),
    .right_hold (right_hold),
    .result     (result)
  );

  // The staged beat moves on whenever the output register is free or is
  // being emptied in this cycle.
  assign advance      = stage_valid && (!mix_valid || !mix_stall);
  assign sample_stall = stage_valid && mix_valid && mix_stall;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= take || (stage_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (advance) begin
      mix_valid <= 1'b1;
    end else if (!mix_stall) begin
      mix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mix <= result;
    end
  end

  // Held motor widths change only when a beat passes both range checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_hold  <= ResetLow;
      right_hold <= ResetLow;
    end else if (advance && result.updated) begin
      left_hold  <= result.left_motor;
      right_hold <= result.right_motor;
    end
  end

endmodule

### hdl/dtm_cfg.sv
// ----------------------------------------------------------------------------
// dtm_cfg: configuration registers
// Four calibration limits, written through a plain index/data write port.
// ----------------------------------------------------------------------------
module dtm_cfg import dtm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  width_t               cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_low  <= ResetLow;
      cfg.throttle_high <= ResetHigh;
      cfg.gyro_low      <= ResetLow;
      cfg.gyro_high     <= ResetHigh;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THROTTLE_LOW:  cfg.throttle_low  <= cfg_data;
        REG_THROTTLE_HIGH: cfg.throttle_high <= cfg_data;
        REG_GYRO_LOW:      cfg.gyro_low      <= cfg_data;
        REG_GYRO_HIGH:     cfg.gyro_high     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/dtm_mix.sv
// ----------------------------------------------------------------------------
// dtm_mix: mixing datapath
// Range checks, halved gyro offset, floor correction and final motor check.
// ----------------------------------------------------------------------------
module dtm_mix import dtm_pkg::*; (
  input  sample_t sample,
  input  cfg_t    cfg,
  input  width_t  left_hold,
  input  width_t  right_hold,
  output mix_t    result
);

  sum_t thr;
  sum_t gyr;
  sum_t offset;
  sum_t left_raw;
  sum_t right_raw;
  sum_t floor_v;
  sum_t left_fix;
  sum_t right_fix;
  logic inputs_ok;
  logic outputs_ok;

  always_comb begin
    thr     = widen(sample.throttle_width);
    gyr     = widen(sample.gyro_width);
    floor_v = widen(cfg.throttle_low);

    // Arithmetic shift halves the offset, rounding toward minus infinity.
    offset    = (gyr - widen(GyroCentre)) >>> 1;
    left_raw  = thr + offset;
    right_raw = thr - offset;

    // A side under the floor is raised to it; the other side gives way.
    priority if (left_raw < floor_v) begin
      left_fix  = floor_v;
      right_fix = right_raw - (floor_v - left_raw);
    end else if (right_raw < floor_v) begin
      right_fix = floor_v;
      left_fix  = left_raw - (floor_v - right_raw);
    end else begin
      left_fix  = left_raw;
      right_fix = right_raw;
    end

    inputs_ok  = within_limits(thr, cfg.throttle_low, cfg.throttle_high) &&
                 within_limits(gyr, cfg.gyro_low, cfg.gyro_high);
    outputs_ok = within_limits(left_fix, cfg.throttle_low, cfg.throttle_high) &&
                 within_limits(right_fix, cfg.throttle_low, cfg.throttle_high);

    result.updated = inputs_ok && outputs_ok;
    if (result.updated) begin
      result.left_motor  = left_fix[RegW-1:0];
      result.right_motor = right_fix[RegW-1:0];
    end else begin
      result.left_motor  = left_hold;
      result.right_motor = right_hold;
    end
  end

endmodule

### sim/differential_throttle_mixer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_throttle_mixer_test: self-checking bench for the throttle mixer
// Drives throttle/gyro pairs under several limit settings and idling patterns,
// predicts each mix beat and compares it field by field with the block.
// ----------------------------------------------------------------------------
module differential_throttle_mixer_test;
  import dtm_pkg::*;

  localparam int     ClkPeriod     = 10;
  localparam int     ResetCycles   = 12;
  localparam int     PhaseCount    = 12;
  localparam int     ItemsPerPhase = 107;
  // The block answers through its input and output registers, so this settle time
  // is enough for anything still in flight to show itself at the end.
  localparam int     SettleCycles  = 8;
  // Longest stretch without any beat on either channel before giving up.
  localparam int     QuietLimit    = 1000;
  localparam int     PrintLimit    = 40;
  localparam width_t WidthMax      = '1;
  localparam width_t WidthZero     = '0;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample       = '0;
  logic                 mix_valid;
  logic                 mix_stall    = 1'b0;
  mix_t                 mix;
  logic                 cfg_write    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index    = REG_THROTTLE_LOW;
  width_t               cfg_data     = '0;

  // Samples waiting to be offered, and the mix beats the block still owes us.
  sample_t sample_backlog[$];
  mix_t    mix_expected[$];

  // Our own copy of the limit registers and of the held motor widths.
  cfg_t   limits;
  width_t held_left;
  width_t held_right;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          fault_count    = 0;
  int          quiet_cycles   = 0;

  differential_throttle_mixer u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .mix_valid    (mix_valid),
    .mix_stall    (mix_stall),
    .mix          (mix),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Inclusive range test on exact signed values; an inverted range accepts
  // nothing at all.
  function automatic bit fits(input int v, input width_t lo, input width_t hi);
    return (v >= int'(lo)) && (v <= int'(hi));
  endfunction

  // Works out the mix beat for one accepted sample and moves the held widths
  // on when the new pair is usable.
  function automatic mix_t mix_sample(input sample_t s);
    int   thr;
    int   gyr;
    int   offset;
    int   left;
    int   right;
    int   floor_w;
    mix_t m;
    thr       = int'(s.throttle_width);
    gyr       = int'(s.gyro_width);
    m.updated = 1'b0;
    if (fits(thr, limits.throttle_low, limits.throttle_high) &&
        fits(gyr, limits.gyro_low, limits.gyro_high)) begin
      // Arithmetic shift, so a negative offset rounds towards minus infinity.
      offset  = (gyr - int'(GyroCentre)) >>> 1;
      left    = thr + offset;
      right   = thr - offset;
      floor_w = int'(limits.throttle_low);
      // A side under the motor floor is lifted to it, and the other side
      // gives up the same amount so the sum of the two is kept.
      if (left < floor_w) begin
        right = right - (floor_w - left);
        left  = floor_w;
      end else if (right < floor_w) begin
        left  = left - (floor_w - right);
        right = floor_w;
      end
      if (fits(left, limits.throttle_low, limits.throttle_high) &&
          fits(right, limits.throttle_low, limits.throttle_high)) begin
        held_left  = width_t'(left);
        held_right = width_t'(right);
        m.updated  = 1'b1;
      end
    end
    m.left_motor  = held_left;
    m.right_motor = held_right;
    return m;
  endfunction

  // Mostly values inside the accepted range (a good share of them close to
  // the floor, where the correction kicks in), then the range boundaries and
  // their neighbours, then anything the field can carry.
  function automatic width_t pick_width(input width_t lo, input width_t hi);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = (hi >= lo) ? int'(hi) - int'(lo) : 0;
    if (hi >= lo && roll < 55) begin
      return width_t'(int'(lo) + $urandom_range(span));
    end
    if (hi >= lo && roll < 72) begin
      return width_t'(int'(lo) + $urandom_range(span < 300 ? span : 300));
    end
    if (roll < 88) begin
      case ($urandom_range(3))
        0: return width_t'(lo - 1'b1);
        1: return lo;
        2: return hi;
        default: return width_t'(hi + 1'b1);
      endcase
    end
    return width_t'($urandom_range(int'(WidthMax)));
  endfunction

  function automatic sample_t draw_sample(input cfg_t c);
    sample_t s;
    s.throttle_width = pick_width(c.throttle_low, c.throttle_high);
    s.gyro_width     = pick_width(c.gyro_low, c.gyro_high);
    return s;
  endfunction

  // Limit settings per phase: the power-on values, both extremes, inverted
  // ranges on either input, a zero floor, a 1000 to 2000 window and random windows.
  function automatic cfg_t phase_limits(input int phase);
    cfg_t c;
    c = '{ResetLow, ResetHigh, ResetLow, ResetHigh};
    case (phase)
      1: c = '{WidthZero, WidthMax, WidthZero, WidthMax};
      2: c = '{width_t'(1000), width_t'(2000), width_t'(1000), width_t'(2000)};
      4: c = '{ResetHigh, ResetLow, ResetLow, ResetHigh};
      5: c = '{ResetLow, ResetHigh, ResetHigh, ResetLow};
      7: c = '{WidthZero, WidthZero, WidthZero, WidthZero};
      8: c = '{WidthMax, WidthMax, WidthMax, WidthMax};
      10: c = '{WidthZero, width_t'(3000), WidthZero, width_t'(3000)};
      3, 6, 9: begin
        c.throttle_low  = width_t'($urandom_range(1200));
        c.throttle_high = width_t'(int'(c.throttle_low) + $urandom_range(3000));
        c.gyro_low      = width_t'($urandom_range(1500));
        c.gyro_high     = width_t'(int'(c.gyro_low) + $urandom_range(3000));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fault_count < PrintLimit) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    fault_count++;
  endtask

  task automatic write_limit(input logic [CfgIndexW-1:0] index, input width_t value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
  endtask

  // Only called once the block is idle: every sample beat has had its answer.
  task automatic load_limits(input cfg_t c);
    write_limit(REG_THROTTLE_LOW, c.throttle_low);
    write_limit(REG_THROTTLE_HIGH, c.throttle_high);
    write_limit(REG_GYRO_LOW, c.gyro_low);
    write_limit(REG_GYRO_HIGH, c.gyro_high);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_pair(input int throttle, input int gyro);
    sample_backlog.push_back('{width_t'(throttle), width_t'(gyro)});
  endtask

  // Each sample beat yields exactly one mix beat, so once nothing is owed the
  // block holds no work at all.
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || sample_valid || mix_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender side. Limit writes and accepted sample beats update our copy of
  // the block at the same edge at which the block itself takes them. A new
  // beat is only offered once the current one has gone, so a stalled beat
  // keeps its payload.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      limits       = '{ResetLow, ResetHigh, ResetLow, ResetHigh};
      held_left    = ResetLow;
      held_right   = ResetLow;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_THROTTLE_LOW:  limits.throttle_low  = cfg_data;
          REG_THROTTLE_HIGH: limits.throttle_high = cfg_data;
          REG_GYRO_LOW:      limits.gyro_low      = cfg_data;
          REG_GYRO_HIGH:     limits.gyro_high     = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        mix_expected.push_back(mix_sample(sample));
      end
      if (!sample_valid || !sample_stall) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample       <= sample_backlog.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks each accepted mix beat against the oldest
  // prediction and throws a fresh stall decision every cycle.
  always @(posedge clk) begin
    mix_t want;
    if (rst) begin
      mix_stall <= 1'b0;
    end else begin
      if (mix_valid && !mix_stall) begin
        if (mix_expected.size() == 0) begin
          report_mismatch("unexpected mix beat, left_motor", int'(mix.left_motor), -1);
        end else begin
          want = mix_expected.pop_front();
          if (mix.left_motor !== want.left_motor) begin
            report_mismatch("left_motor", int'(mix.left_motor), int'(want.left_motor));
          end
          if (mix.right_motor !== want.right_motor) begin
            report_mismatch("right_motor", int'(mix.right_motor), int'(want.right_motor));
          end
          if (mix.updated !== want.updated) begin
            report_mismatch("updated", int'(mix.updated), int'(want.updated));
          end
        end
      end
      mix_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a long stretch with no beat on either channel means the block
  // has hung or swallowed a beat.
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (mix_valid && !mix_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[differential_throttle_mixer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t phase_cfg;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Sender idles now and then, receiver stalls most of the time.
    send_idle_pct  = 17;
    recv_stall_pct = 64;

    // Directed beats under the power-on limits (700 to 2300 on both inputs).
    queue_pair(0, 0);
    queue_pair(int'(WidthMax), int'(WidthMax));
    queue_pair(1500, 1500);
    queue_pair(700, 1500);
    queue_pair(2300, 1500);
    queue_pair(699, 1500);        // throttle just under its range
    queue_pair(2301, 1500);       // throttle just over its range
    queue_pair(1500, 699);        // gyro just under its range
    queue_pair(1500, 2301);       // gyro just over its range
    queue_pair(1500, 700);
    queue_pair(1500, 2300);
    queue_pair(1500, 1499);       // odd negative offset rounds down to -1
    queue_pair(1500, 1501);       // odd positive offset rounds down to 0
    queue_pair(1500, 1502);
    queue_pair(700, 1000);        // left under the floor, right lowered
    queue_pair(800, 2300);        // right under the floor, left lowered
    queue_pair(1000, 2300);
    queue_pair(700, 700);         // both sides land exactly on the floor
    queue_pair(2300, 2000);       // left over the motor ceiling: held
    queue_pair(2200, 1000);       // right over the motor ceiling: held
    queue_pair(int'(WidthMax), 1500);
    queue_pair(1500, 'h5555);
    queue_pair('h2AAA, 1500);
    wait_drained();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase == 4) begin
        send_idle_pct  = 64;
        recv_stall_pct = 17;
      end else if (phase == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      phase_cfg = phase_limits(phase);
      load_limits(phase_cfg);
      repeat (ItemsPerPhase) sample_backlog.push_back(draw_sample(phase_cfg));
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("[differential_throttle_mixer] OK");
    end else begin
      $display("[differential_throttle_mixer] ERROR");
    end
    $finish;
  end

endmodule
